// File: rtl/rbei_pkg.sv
// ----------------------------------------------------------------------------
// rbei_pkg: shared constants
// Widths, command and status codes, register indexes and reset values used by
// the point-mass integrator core and its testbench.
// ----------------------------------------------------------------------------
package rbei_pkg;

  localparam int unsigned MaxBodiesDefault = 64;
  localparam int unsigned DataW = 32;
  localparam int unsigned IdW = 7;

  localparam logic [2:0] ModeCreate = 3'd0;
  localparam logic [2:0] ModeSetVel = 3'd1;
  localparam logic [2:0] ModeApply  = 3'd2;
  localparam logic [2:0] ModeRead   = 3'd3;
  localparam logic [2:0] ModeStep   = 3'd4;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StInvalid  = 2'd1;
  localparam logic [1:0] StNotFound = 2'd2;
  localparam logic [1:0] StFull     = 2'd3;

  localparam logic [1:0] RegGravX = 2'd0;
  localparam logic [1:0] RegGravY = 2'd1;
  localparam logic [1:0] RegGravZ = 2'd2;

  localparam logic signed [31:0] GravYReset = -32'sd642908;

endpackage

// File: rtl/rbei_ram.sv
// ----------------------------------------------------------------------------
// rbei_ram: generic single-port RAM
// Reads every cycle and may also write the same address; read data registered.
// ----------------------------------------------------------------------------
module rbei_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// File: rtl/rigid_body_euler_integrator_core.sv
// ----------------------------------------------------------------------------
// rigid_body_euler_integrator_core: point-mass table with Euler integration
// Keeps up to MaxBodies bodies in Q16.16 and runs create, set, apply, read and
// step commands through one shared sequencer.
// ----------------------------------------------------------------------------
// The core takes one command transaction at a time and returns exactly one
// result transaction for it. Bodies are numbered 1, 2, 3 ... in order of
// creation. Each command runs through a small sequencer that drives one shared
// 32 x 32 signed multiplier, one saturating adder and one single-port RAM per
// store. Set, apply and read run an address, a data and an advance step per axis,
// and a create runs a restoring division of 33 quotient bits that forms the
// inverse mass and then writes the three axes. A step walks every body: per axis
// it reads force, velocity, position and inverse mass, does three multiplications
// and writes back, in read, wait, multiply and write-back steps. Every command
// also passes through the result register. Gravity registers are written through
// the configuration port; the user must write them only while the core is idle,
// which the core does not enforce. The result is held in an output register until
// it is taken, and no new command is taken before then.
module rigid_body_euler_integrator_core
  import rbei_pkg::*;
#(
  parameter int unsigned MaxBodies = MaxBodiesDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         mode_i,
  input  logic [6:0]         body_id_i,
  input  logic signed [31:0] vec_x_i,
  input  logic signed [31:0] vec_y_i,
  input  logic signed [31:0] vec_z_i,
  input  logic signed [31:0] body_mass_i,
  input  logic signed [31:0] time_step_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [6:0]         new_id_o,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o,
  output logic signed [31:0] vel_x_o,
  output logic signed [31:0] vel_y_o,
  output logic signed [31:0] vel_z_o
);

  localparam int unsigned VecDepth = 3 * MaxBodies;
  localparam int unsigned VecAw = $clog2(VecDepth);
  localparam int unsigned BodyAw = (MaxBodies > 1) ? $clog2(MaxBodies) : 1;
  localparam int unsigned CntW = $clog2(MaxBodies + 1) + 1;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_DIV   = 13'b0000000000010,
    S_CWR   = 13'b0000000000100,
    S_RD    = 13'b0000000001000,
    S_RDW   = 13'b0000000010000,
    S_RDU   = 13'b0000000100000,
    S_SRD   = 13'b0000001000000,
    S_SWT   = 13'b0000010000000,
    S_SM1   = 13'b0000100000000,
    S_SM2   = 13'b0001000000000,
    S_SM3   = 13'b0010000000000,
    S_SWB   = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  logic signed [31:0] grav_q [3];
  logic [CntW-1:0] next_id_q, next_id_d;

  // command latch
  logic [2:0]         mode_q;
  logic [BodyAw-1:0]  slot_q;
  logic signed [31:0] vec_q [3];
  logic signed [31:0] dt_q;

  logic [1:0]  axis_q, axis_d;
  logic [BodyAw-1:0] body_q, body_d;
  logic [5:0]  bit_q, bit_d;

  // divider
  logic [31:0] rem_q, rem_d;
  logic [32:0] quo_q, quo_d;
  logic [31:0] den_q;

  // step working values
  logic signed [31:0] f_q, f_d, v_q, v_d, p_q, p_d, im_q, im_d, acc_q, acc_d;

  // result register
  logic [1:0]  st_q, st_d;
  logic [6:0]  nid_q, nid_d;
  logic signed [31:0] rp_q [3];
  logic signed [31:0] rv_q [3];
  logic signed [31:0] rp_d [3];
  logic signed [31:0] rv_d [3];

  // memories
  logic             pos_we, vel_we, frc_we, inv_we;
  logic [VecAw-1:0] vaddr;
  logic [BodyAw-1:0] iaddr;
  logic [31:0] pos_wd, vel_wd, frc_wd, inv_wd;
  logic [31:0] pos_rd, vel_rd, frc_rd, inv_rd;

  rbei_ram #(.Width(32), .Depth(VecDepth)) u_pos (
    .clk_i, .we_i(pos_we), .addr_i(vaddr), .wdata_i(pos_wd), .rdata_o(pos_rd));
  rbei_ram #(.Width(32), .Depth(VecDepth)) u_vel (
    .clk_i, .we_i(vel_we), .addr_i(vaddr), .wdata_i(vel_wd), .rdata_o(vel_rd));
  rbei_ram #(.Width(32), .Depth(VecDepth)) u_frc (
    .clk_i, .we_i(frc_we), .addr_i(vaddr), .wdata_i(frc_wd), .rdata_o(frc_rd));
  rbei_ram #(.Width(32), .Depth(MaxBodies)) u_inv (
    .clk_i, .we_i(inv_we), .addr_i(iaddr), .wdata_i(inv_wd), .rdata_o(inv_rd));

  // Shared multiplier: floor Q16.16 product with saturation.
  logic signed [31:0] mul_a, mul_b, mul_r;
  logic signed [63:0] prod;
  logic signed [47:0] prod_sh;
  always_comb begin
    prod    = 64'(mul_a) * 64'(mul_b);
    prod_sh = prod[63:16];
    if (prod_sh > 48'sh0000_7FFF_FFFF) begin
      mul_r = 32'sh7FFF_FFFF;
    end else if (prod_sh < -48'sh0000_8000_0000) begin
      mul_r = 32'sh8000_0000;
    end else begin
      mul_r = prod_sh[31:0];
    end
  end

  // Shared saturating adder.
  logic signed [31:0] add_a, add_b, add_r;
  logic signed [32:0] sum;
  always_comb begin
    sum = 33'(add_a) + 33'(add_b);
    if (sum[32] != sum[31]) begin
      add_r = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      add_r = sum[31:0];
    end
  end

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  logic [CntW-1:0] id_ext;
  logic            known;
  logic [CntW-1:0] nbodies;
  assign id_ext  = CntW'(body_id_i);
  assign known   = (body_id_i != '0) && (id_ext < next_id_q);
  assign nbodies = next_id_q - CntW'(1);

  logic [VecAw-1:0] base_slot, base_body;
  assign base_slot = VecAw'(3 * 32'(slot_q)) + VecAw'(axis_q);
  assign base_body = VecAw'(3 * 32'(body_q)) + VecAw'(axis_q);

  // The partial remainder stays below the mass, so it always fits in 31 bits.
  logic [32:0] trial;
  assign trial = {rem_q, quo_q[32]} - {1'b0, den_q};

  always_comb begin
    state_d = state_q;
    next_id_d = next_id_q;
    axis_d = axis_q;
    body_d = body_q;
    bit_d = bit_q;
    rem_d = rem_q;
    quo_d = quo_q;
    f_d = f_q; v_d = v_q; p_d = p_q; im_d = im_q; acc_d = acc_q;
    st_d = st_q; nid_d = nid_q;
    rp_d = rp_q; rv_d = rv_q;
    pos_we = 1'b0; vel_we = 1'b0; frc_we = 1'b0; inv_we = 1'b0;
    pos_wd = '0; vel_wd = '0; frc_wd = '0; inv_wd = '0;
    vaddr = base_slot;
    iaddr = slot_q;
    mul_a = '0; mul_b = '0;
    add_a = '0; add_b = '0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          st_d = StOk; nid_d = '0;
          for (int k = 0; k < 3; k++) begin
            rp_d[k] = '0; rv_d[k] = '0;
          end
          axis_d = '0; body_d = '0; bit_d = '0;
          case (mode_i)
            ModeCreate: begin
              if (body_mass_i <= 0) begin
                st_d = StInvalid; state_d = S_OUT;
              end else if (nbodies >= CntW'(MaxBodies)) begin
                st_d = StFull; state_d = S_OUT;
              end else begin
                rem_d = '0;
                quo_d = 33'h1_0000_0000;
                state_d = S_DIV;
              end
            end
            ModeSetVel, ModeApply, ModeRead: begin
              if (!known) begin
                st_d = StNotFound; state_d = S_OUT;
              end else begin
                state_d = S_RD;
              end
            end
            ModeStep: begin
              if (time_step_i <= 0) begin
                st_d = StInvalid; state_d = S_OUT;
              end else if (nbodies == '0) begin
                state_d = S_OUT;
              end else begin
                state_d = S_SRD;
              end
            end
            default: begin
              st_d = StInvalid; state_d = S_OUT;
            end
          endcase
        end
      end

      // restoring division of 2^32 by the mass, one quotient bit a cycle
      S_DIV: begin
        if (!trial[32]) begin
          rem_d = trial[31:0];
          quo_d = {quo_q[31:0], 1'b1};
        end else begin
          rem_d = {rem_q[30:0], quo_q[32]};
          quo_d = {quo_q[31:0], 1'b0};
        end
        bit_d = bit_q + 6'd1;
        if (bit_q == 6'd32) begin
          state_d = S_CWR;
        end
      end

      S_CWR: begin
        pos_we = 1'b1; vel_we = 1'b1; frc_we = 1'b1;
        pos_wd = vec_q[axis_q];
        if (axis_q == 2'd0) begin
          inv_we = 1'b1;
          inv_wd = (quo_q[32:31] != 2'b00) ? 32'h7FFF_FFFF : quo_q[31:0];
        end
        axis_d = axis_q + 2'd1;
        if (axis_q == 2'd2) begin
          nid_d = next_id_q[6:0];
          next_id_d = next_id_q + CntW'(1);
          state_d = S_OUT;
        end
      end

      S_RD: begin
        state_d = S_RDW;
      end

      S_RDW: begin
        case (mode_q)
          ModeSetVel: begin
            vel_we = 1'b1; vel_wd = vec_q[axis_q];
          end
          ModeApply: begin
            add_a = frc_rd; add_b = vec_q[axis_q];
            frc_we = 1'b1; frc_wd = add_r;
          end
          default: begin
            rp_d[axis_q] = pos_rd; rv_d[axis_q] = vel_rd;
          end
        endcase
        state_d = S_RDU;
      end

      S_RDU: begin
        axis_d = axis_q + 2'd1;
        state_d = (axis_q == 2'd2) ? S_OUT : S_RD;
      end

      S_SRD: begin
        vaddr = base_body; iaddr = body_q;
        state_d = S_SWT;
      end

      S_SWT: begin
        vaddr = base_body; iaddr = body_q;
        f_d = frc_rd; v_d = vel_rd; p_d = pos_rd; im_d = inv_rd;
        state_d = S_SM1;
      end

      S_SM1: begin
        vaddr = base_body;
        mul_a = f_q; mul_b = im_q;
        add_a = grav_q[axis_q]; add_b = mul_r;
        acc_d = add_r;
        state_d = S_SM2;
      end

      S_SM2: begin
        vaddr = base_body;
        mul_a = acc_q; mul_b = dt_q;
        add_a = v_q; add_b = mul_r;
        v_d = add_r;
        state_d = S_SM3;
      end

      S_SM3: begin
        vaddr = base_body;
        mul_a = v_q; mul_b = dt_q;
        add_a = p_q; add_b = mul_r;
        p_d = add_r;
        state_d = S_SWB;
      end

      S_SWB: begin
        vaddr = base_body;
        pos_we = 1'b1; vel_we = 1'b1; frc_we = 1'b1;
        pos_wd = p_q; vel_wd = v_q; frc_wd = '0;
        if (axis_q == 2'd2) begin
          axis_d = '0;
          if (CntW'(body_q) + CntW'(1) >= nbodies) begin
            state_d = S_OUT;
          end else begin
            body_d = body_q + BodyAw'(1);
            state_d = S_SRD;
          end
        end else begin
          axis_d = axis_q + 2'd1;
          state_d = S_SRD;
        end
      end

      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      next_id_q <= CntW'(1);
      grav_q[0] <= '0;
      grav_q[1] <= GravYReset;
      grav_q[2] <= '0;
    end else begin
      state_q   <= state_d;
      next_id_q <= next_id_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegGravX: grav_q[0] <= cfg_data_i;
          RegGravY: grav_q[1] <= cfg_data_i;
          RegGravZ: grav_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q   <= mode_i;
      slot_q   <= (mode_i == ModeCreate) ? BodyAw'(nbodies)
                                         : BodyAw'(body_id_i - 7'd1);
      vec_q[0] <= vec_x_i;
      vec_q[1] <= vec_y_i;
      vec_q[2] <= vec_z_i;
      dt_q     <= time_step_i;
      den_q    <= body_mass_i;
    end
    axis_q <= axis_d; body_q <= body_d; bit_q <= bit_d;
    rem_q <= rem_d; quo_q <= quo_d;
    f_q <= f_d; v_q <= v_d; p_q <= p_d; im_q <= im_d; acc_q <= acc_d;
    st_q <= st_d; nid_q <= nid_d;
    rp_q <= rp_d; rv_q <= rv_d;
  end

  assign out_valid_o = (state_q == S_OUT);
  assign status_o = st_q;
  assign new_id_o = nid_q;
  assign pos_x_o = rp_q[0];
  assign pos_y_o = rp_q[1];
  assign pos_z_o = rp_q[2];
  assign vel_x_o = rv_q[0];
  assign vel_y_o = rv_q[1];
  assign vel_z_o = rv_q[2];

endmodule

// File: sim/rbei_checker.sv
// ----------------------------------------------------------------------------
// rbei_checker: result predictor and comparator for the point-mass core
// Watches the command, result and register-write ports, keeps its own copy
// of the body table and predicts every result, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbei_checker
  import rbei_pkg::*;
#(
  parameter int unsigned MaxBodies = MaxBodiesDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [2:0]         mode_i,
  input  logic [6:0]         body_id_i,
  input  logic signed [31:0] vec_x_i,
  input  logic signed [31:0] vec_y_i,
  input  logic signed [31:0] vec_z_i,
  input  logic signed [31:0] body_mass_i,
  input  logic signed [31:0] time_step_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [1:0]         status_i,
  input  logic [6:0]         new_id_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic signed [31:0] vel_z_i,
  output int                 pending_o,
  output int                 fail_count_o
);

  typedef struct {
    logic [1:0]         status;
    logic [6:0]         new_id;
    logic signed [31:0] pos [3];
    logic signed [31:0] vel [3];
  } body_result_t;

  body_result_t       expected_results [$];
  logic signed [31:0] grav [3];
  logic signed [31:0] body_pos [3*MaxBodies];
  logic signed [31:0] body_vel [3*MaxBodies];
  logic signed [31:0] body_force [3*MaxBodies];
  logic signed [31:0] body_inv_mass [MaxBodies];
  int unsigned        model_next_id;

  function automatic logic signed [31:0] sat32(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // Exact product, arithmetic shift gives the floor, then saturate.
  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return sat32(p >>> 16);
  endfunction

  task automatic predict_command(input logic [2:0] mode, input logic [6:0] id,
                                 input logic signed [31:0] vec [3],
                                 input logic signed [31:0] mass,
                                 input logic signed [31:0] dt);
    body_result_t       r;
    bit                 known;
    int unsigned        base;
    int unsigned        i;
    longint unsigned    inv;
    logic signed [31:0] acc;
    r.status = StOk;
    r.new_id = '0;
    for (int k = 0; k < 3; k++) begin
      r.pos[k] = '0;
      r.vel[k] = '0;
    end
    known = (id >= 1) && (id < model_next_id);
    base  = known ? 3 * (id - 1) : 0;
    case (mode)
      ModeCreate: begin
        if (mass <= 0) begin
          r.status = StInvalid;
        end else if (model_next_id - 1 >= MaxBodies) begin
          r.status = StFull;
        end else begin
          inv = 64'h1_0000_0000 / {32'b0, mass};
          if (inv > 64'h7FFF_FFFF) inv = 64'h7FFF_FFFF;
          body_inv_mass[model_next_id-1] = inv[31:0];
          for (int k = 0; k < 3; k++) begin
            body_pos[3*(model_next_id-1)+k]   = vec[k];
            body_vel[3*(model_next_id-1)+k]   = '0;
            body_force[3*(model_next_id-1)+k] = '0;
          end
          r.new_id = model_next_id[6:0];
          model_next_id++;
        end
      end
      ModeSetVel, ModeApply, ModeRead: begin
        if (!known) begin
          r.status = StNotFound;
        end else begin
          for (int k = 0; k < 3; k++) begin
            i = base + k;
            if (mode == ModeSetVel) body_vel[i] = vec[k];
            else if (mode == ModeApply)
              body_force[i] = sat32(longint'(body_force[i]) + longint'(vec[k]));
            else begin
              r.pos[k] = body_pos[i];
              r.vel[k] = body_vel[i];
            end
          end
        end
      end
      ModeStep: begin
        if (dt <= 0) begin
          r.status = StInvalid;
        end else begin
          // Symplectic Euler: the freshly updated velocity moves the position.
          for (int b = 0; b + 1 < model_next_id && b < MaxBodies; b++) begin
            for (int k = 0; k < 3; k++) begin
              i = 3 * b + k;
              acc = sat32(longint'(grav[k]) +
                          longint'(qmul(body_force[i], body_inv_mass[b])));
              body_vel[i] = sat32(longint'(body_vel[i]) + longint'(qmul(acc, dt)));
              body_pos[i] = sat32(longint'(body_pos[i]) +
                                  longint'(qmul(body_vel[i], dt)));
              body_force[i] = '0;
            end
          end
        end
      end
      default: r.status = StInvalid;
    endcase
    expected_results.push_back(r);
  endtask

  task automatic report(input string field, input logic [31:0] exp_v,
                        input logic [31:0] act_v);
    $display("%0t: mismatch on %s, expected %h, actual %h", $time, field, exp_v, act_v);
    fail_count_o++;
  endtask

  task automatic check_result();
    body_result_t       e;
    logic signed [31:0] act_pos [3];
    logic signed [31:0] act_vel [3];
    act_pos = '{pos_x_i, pos_y_i, pos_z_i};
    act_vel = '{vel_x_i, vel_y_i, vel_z_i};
    if (expected_results.size() == 0) begin
      $display("%0t: result transaction with nothing expected, status %h", $time, status_i);
      fail_count_o++;
      return;
    end
    e = expected_results.pop_front();
    if (status_i !== e.status) report("status", 32'(e.status), 32'(status_i));
    if (new_id_i !== e.new_id) report("new_id", 32'(e.new_id), 32'(new_id_i));
    for (int k = 0; k < 3; k++) begin
      if (act_pos[k] !== e.pos[k]) report($sformatf("pos[%0d]", k), e.pos[k], act_pos[k]);
      if (act_vel[k] !== e.vel[k]) report($sformatf("vel[%0d]", k), e.vel[k], act_vel[k]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [31:0] vec [3];
    if (!rst_ni) begin
      grav = '{32'sd0, GravYReset, 32'sd0};
      model_next_id = 1;
      expected_results.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_result();
      if (cfg_we_i) begin
        if (cfg_index_i == RegGravX) grav[0] = cfg_data_i;
        else if (cfg_index_i == RegGravY) grav[1] = cfg_data_i;
        else if (cfg_index_i == RegGravZ) grav[2] = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) begin
        vec = '{vec_x_i, vec_y_i, vec_z_i};
        predict_command(mode_i, body_id_i, vec, body_mass_i, time_step_i);
      end
    end
    pending_o = expected_results.size();
  end

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the point-mass Euler integrator core
// Drives a directed set of commands and then long runs of random ones under
// several gravity settings, with random idling on both channels in all but
// one phase; a checker predicts and compares every result transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import rbei_pkg::*;

  // A full step walks all 64 bodies, so both channels may stay quiet for the
  // whole step; only a far longer silence is taken as a hang.
  localparam int unsigned WatchdogLimit = 50000;
  localparam int unsigned PhaseItems    = 385;
  localparam logic [2:0]  ModeLast      = 3'd7;

  typedef struct {
    logic [2:0]         mode;
    logic [6:0]         id;
    logic signed [31:0] vx, vy, vz;
    logic signed [31:0] mass;
    logic signed [31:0] dt;
  } body_cmd_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_index_i = '0;
  logic [31:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [2:0]         mode_i = '0;
  logic [6:0]         body_id_i = '0;
  logic signed [31:0] vec_x_i = '0, vec_y_i = '0, vec_z_i = '0;
  logic signed [31:0] body_mass_i = '0, time_step_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         status_o;
  logic [6:0]         new_id_o;
  logic signed [31:0] pos_x_o, pos_y_o, pos_z_o, vel_x_o, vel_y_o, vel_z_o;

  int  pending_results;
  int  fail_count;
  bit  no_idle;       // a phase with no idling on either side
  int  result_hold;
  int  quiet_cycles;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  rigid_body_euler_integrator_core i_dut (.*);

  rbei_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .mode_i, .body_id_i,
    .vec_x_i, .vec_y_i, .vec_z_i, .body_mass_i, .time_step_i,
    .out_valid_i(out_valid_o), .out_stall_i, .status_i(status_o),
    .new_id_i(new_id_o), .pos_x_i(pos_x_o), .pos_y_i(pos_y_o), .pos_z_i(pos_z_o),
    .vel_x_i(vel_x_o), .vel_y_i(vel_y_o), .vel_z_i(vel_z_o),
    .pending_o(pending_results), .fail_count_o(fail_count)
  );

  // The result side holds results back at random, except in the no-idle phase.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_hold = 0;
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) result_hold = no_idle ? 0 : $urandom_range(0, 5);
      else if (out_valid_o && result_hold > 0) result_hold--;
      out_stall_i <= (result_hold != 0);
    end
  end

  // Watchdog: counts cycles in which neither channel moves a transaction.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // One command transaction, preceded by a random gap. The stall is sampled on
  // the falling edge, where it is settled for the coming rising edge.
  task automatic send_cmd(input body_cmd_t c);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= c.mode;
    body_id_i   <= c.id;
    vec_x_i     <= c.vx;
    vec_y_i     <= c.vy;
    vec_z_i     <= c.vz;
    body_mass_i <= c.mass;
    time_step_i <= c.dt;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
  endtask

  task automatic send(input logic [2:0] mode, input logic [6:0] id,
                      input logic [31:0] vx, input logic [31:0] vy,
                      input logic [31:0] vz, input logic [31:0] mass,
                      input logic [31:0] dt);
    body_cmd_t c;
    c = '{mode, id, vx, vy, vz, mass, dt};
    send_cmd(c);
  endtask

  // Gravity is only written once every result is back and the core is idle.
  task automatic write_gravity(input logic [31:0] gx, input logic [31:0] gy,
                               input logic [31:0] gz);
    logic [31:0] vals [3];
    vals = '{gx, gy, gz};
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    for (int k = 0; k < 3; k++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= 2'(k);
      cfg_data_i  <= vals[k];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_vec();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom;
      default: return 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
    endcase
  endfunction

  function automatic logic [31:0] rand_mass();
    case ($urandom_range(0, 11))
      0:       return 32'h0;
      1:       return $urandom | 32'h8000_0000;
      2:       return 32'h1;
      3:       return 32'h7FFF_FFFF;
      4:       return $urandom;
      default: return 32'($urandom_range(1 << 12, 1 << 22));
    endcase
  endfunction

  function automatic logic [31:0] rand_dt();
    case ($urandom_range(0, 11))
      0:       return 32'h0;
      1:       return $urandom | 32'h8000_0000;
      2:       return 32'h7FFF_FFFF;
      3:       return $urandom & 32'h7FFF_FFFF;
      default: return 32'($urandom_range(1, 1 << 12));
    endcase
  endfunction

  function automatic logic [6:0] rand_id();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 7'($urandom_range(65, 127));
      default: return 7'($urandom_range(1, 64));
    endcase
  endfunction

  function automatic body_cmd_t rand_cmd();
    body_cmd_t c;
    int        pick;
    pick = $urandom_range(0, 99);
    if (pick < 15)      c.mode = ModeCreate;
    else if (pick < 30) c.mode = ModeSetVel;
    else if (pick < 52) c.mode = ModeApply;
    else if (pick < 84) c.mode = ModeRead;
    else if (pick < 93) c.mode = ModeStep;
    else                c.mode = 3'($urandom_range(ModeStep + 1, ModeLast));
    c.id   = rand_id();
    c.vx   = rand_vec();
    c.vy   = rand_vec();
    c.vz   = rand_vec();
    c.mass = rand_mass();
    c.dt   = rand_dt();
    return c;
  endfunction

  initial begin
    no_idle = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, under the reset gravity: rejected commands first, then
    // bodies at the field extremes driven into saturation.
    send(ModeRead,   7'd0,   0, 0, 0, 0, 0);
    send(ModeCreate, 7'd0,   0, 0, 0, 32'h0, 0);
    send(ModeCreate, 7'd0,   0, 0, 0, 32'h8000_0000, 0);
    send(ModeStep,   7'd0,   0, 0, 0, 0, 32'h0);
    send(ModeStep,   7'd0,   0, 0, 0, 0, 32'hFFFF_FFFF);
    for (int m = ModeStep + 1; m <= ModeLast; m++) send(3'(m), 7'd1, 0, 0, 0, 1, 1);
    send(ModeCreate, 7'd0,   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1, 0);
    send(ModeCreate, 7'd0,   32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
         32'h7FFF_FFFF, 0);
    send(ModeSetVel, 7'd1,   32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 0, 0);
    send(ModeApply,  7'd2,   32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 0, 0);
    send(ModeApply,  7'd2,   32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 0, 0);
    send(ModeRead,   7'd1,   0, 0, 0, 0, 0);
    send(ModeRead,   7'd3,   0, 0, 0, 0, 0);
    send(ModeApply,  7'd127, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
    send(ModeStep,   7'd0,   0, 0, 0, 0, 32'h1);
    send(ModeStep,   7'd0,   0, 0, 0, 0, 32'h7FFF_FFFF);
    send(ModeRead,   7'd1,   0, 0, 0, 0, 0);
    send(ModeRead,   7'd2,   0, 0, 0, 0, 0);

    // Random phases, each under its own gravity. The extremes come first; the
    // pause before every write also lets the core drain completely.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       write_gravity(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        1:       write_gravity(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        2:       write_gravity(32'h0, GravYReset, 32'h0);
        default: write_gravity(32'($urandom_range(0, 1 << 21)) - 32'(1 << 20),
                               32'($urandom_range(0, 1 << 21)) - 32'(1 << 20),
                               $urandom);
      endcase
      no_idle = (phase == 2);
      for (int n = 0; n < PhaseItems; n++) send_cmd(rand_cmd());
    end
    no_idle = 1'b0;
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
